[sv/fgn_pkg.sv]
// ----------------------------------------------------------------------------
// fgn_pkg
// Shared types and constants for the fractal gradient noise pipeline.
// ----------------------------------------------------------------------------
package fgn_pkg;

    localparam int DEF_TILE_SIZE  = 256;
    localparam int DEF_OCTAVES    = 6;
    localparam int DEF_BASE_CELLS = 2;

    localparam int TEX_W   = 8;
    localparam int TEX_N   = 256;
    localparam int FRAC_W  = 16;
    localparam int NOISE_W = 16;
    localparam int TOTAL_W = 48;

    // APB register map
    localparam int          PADDR_W       = 3;
    localparam logic [0:0]  REG_BASE_SEED = 1'b0;
    localparam logic [31:0] SEED_RESET    = 32'h9e37_79b9;

    // lattice hash multipliers
    localparam logic [31:0] HASH_X_MUL    = 32'd1664525;
    localparam logic [31:0] HASH_Y_MUL    = 32'd1013904223;
    localparam logic [31:0] HASH_SEED_MUL = 32'd374761393;
    localparam logic [31:0] HASH_MIX1     = 32'h2c1b_3c6d;
    localparam logic [31:0] HASH_MIX2     = 32'h297a_2d39;

    // compass gradients, Q1.15
    localparam logic signed [15:0] GRAD_X [8] = '{
        16'sd32767, -16'sd32767, 16'sd0, 16'sd0,
        16'sd23170, -16'sd23170, 16'sd23170, -16'sd23170
    };
    localparam logic signed [15:0] GRAD_Y [8] = '{
        16'sd0, 16'sd0, 16'sd32767, -16'sd32767,
        16'sd23170, 16'sd23170, -16'sd23170, -16'sd23170
    };

    // handoff between neighboring octave cells
    typedef struct packed {
        logic                      valid;
        logic [TEX_W-1:0]          tex_x;
        logic [TEX_W-1:0]          tex_y;
        logic signed [TOTAL_W-1:0] total;
    } t_cell_bus;

endpackage

[sv/fgn_in_if.sv]
// ----------------------------------------------------------------------------
// fgn_in_if
// Texel coordinate channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fgn_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] tex_x;
    logic [7:0] tex_y;

    modport source (output valid, output tex_x, output tex_y, input ready);
    modport sink   (input valid, input tex_x, input tex_y, output ready);
endinterface

[sv/fgn_out_if.sv]
// ----------------------------------------------------------------------------
// fgn_out_if
// Noise value channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fgn_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] noise_value;

    modport source (output valid, output noise_value, input ready);
    modport sink   (input valid, input noise_value, output ready);
endinterface

[sv/tileable_fractal_gradient_noise.sv]
// ----------------------------------------------------------------------------
// tileable_fractal_gradient_noise - one texel in, one noise value out
// Takes one texel per cycle unless the skid register is occupied; ten
// stages per octave cell, then a three-stage normalizer with a reciprocal
// multiply. Sync reset clears valids, the skid buffer and loads base_seed
// with 0x9e3779b9.
// ----------------------------------------------------------------------------
module tileable_fractal_gradient_noise #(
    parameter int TILE_SIZE  = fgn_pkg::DEF_TILE_SIZE,
    parameter int OCTAVES    = fgn_pkg::DEF_OCTAVES,
    parameter int BASE_CELLS = fgn_pkg::DEF_BASE_CELLS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    fgn_in_if.sink                       i_tex,
    fgn_out_if.source                    o_noise,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fgn_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    // ------------------------------------------------------------------
    // Configuration: base_seed at byte address 0. Writes land on the
    // access phase; pready is tied high so there are no wait states.
    // ------------------------------------------------------------------
    logic        w_cfg_wr;
    logic [31:0] r_base_seed;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_seed <= fgn_pkg::SEED_RESET;
        end else if (w_cfg_wr && (paddr[2] == fgn_pkg::REG_BASE_SEED)) begin
            r_base_seed <= pwdata;
        end
    end

    always_comb begin
        unique case (paddr[2])
            fgn_pkg::REG_BASE_SEED: prdata = r_base_seed;
            default:                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline enable. The whole datapath advances together; it only
    // holds when the skid register is occupied, so ready is registered
    // and an item is taken even while a result waits at the output.
    // ------------------------------------------------------------------
    logic w_en;
    logic r_skid_vld;

    assign w_en        = !r_skid_vld;
    assign i_tex.ready = w_en;

    // ------------------------------------------------------------------
    // Chain of octave cells. Each cell evaluates one octave, adds its
    // weighted value to the running sum and passes texel and sum on.
    // ------------------------------------------------------------------
    fgn_pkg::t_cell_bus w_head;
    fgn_pkg::t_cell_bus w_link [OCTAVES];

    assign w_head.valid = i_tex.valid && w_en;
    assign w_head.tex_x = i_tex.tex_x;
    assign w_head.tex_y = i_tex.tex_y;
    assign w_head.total = '0;

    for (genvar k = 0; k < OCTAVES; k++) begin : g_cell
        fgn_pkg::t_cell_bus w_cell_in;

        if (k == 0) begin : g_head
            assign w_cell_in = w_head;
        end else begin : g_link
            assign w_cell_in = w_link[k-1];
        end

        fgn_octave_cell #(
            .TILE_SIZE  (TILE_SIZE),
            .OCTAVES    (OCTAVES),
            .BASE_CELLS (BASE_CELLS),
            .OCT        (k)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_en        (w_en),
            .i_base_seed (r_base_seed),
            .i_bus       (w_cell_in),
            .o_bus       (w_link[k])
        );
    end

    // ------------------------------------------------------------------
    // Normalize: divide by the weight total with round-to-nearest and
    // saturate to Q1.15.
    // ------------------------------------------------------------------
    logic                                w_div_vld;
    logic signed [fgn_pkg::NOISE_W-1:0]  w_div_noise;

    fgn_div #(
        .OCTAVES (OCTAVES)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_link[OCTAVES-1].valid),
        .i_total (w_link[OCTAVES-1].total),
        .o_vld   (w_div_vld),
        .o_noise (w_div_noise)
    );

    // ------------------------------------------------------------------
    // Output register plus skid register. A transaction leaving the
    // divider goes to the output register if it is free or being taken,
    // else it parks in the skid register and the pipeline holds.
    // ------------------------------------------------------------------
    logic                                r_out_vld,    n_out_vld;
    logic signed [fgn_pkg::NOISE_W-1:0]  r_out_noise,  n_out_noise;
    logic                                n_skid_vld;
    logic signed [fgn_pkg::NOISE_W-1:0]  r_skid_noise, n_skid_noise;

    always_comb begin
        n_out_vld    = r_out_vld;
        n_out_noise  = r_out_noise;
        n_skid_vld   = r_skid_vld;
        n_skid_noise = r_skid_noise;
        if (!r_out_vld || o_noise.ready) begin
            if (r_skid_vld) begin
                // drain the parked result first
                n_out_vld   = 1'b1;
                n_out_noise = r_skid_noise;
                n_skid_vld  = 1'b0;
            end else begin
                n_out_vld   = w_div_vld;
                n_out_noise = w_div_noise;
            end
        end else if (w_div_vld && !r_skid_vld) begin
            // output is held: park the arriving result
            n_skid_vld   = 1'b1;
            n_skid_noise = w_div_noise;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_noise  <= n_out_noise;
        r_skid_noise <= n_skid_noise;
    end

    assign o_noise.valid       = r_out_vld;
    assign o_noise.noise_value = r_out_noise;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_behind_out: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld
    ) else $error("skid register holds a result while the output is empty");

    a_skid_fill_on_stall: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_out_vld && !o_noise.ready)
    ) else $error("skid register filled without an output stall");

    a_seed_write: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_cfg_wr && (paddr[2] == fgn_pkg::REG_BASE_SEED))
            |=> (r_base_seed == $past(pwdata))
    ) else $error("base_seed write was lost");

endmodule

[sv/fgn_fade.sv]
// ----------------------------------------------------------------------------
// fgn_fade
// Quintic fade 6t^5 - 15t^4 + 10t^3 in Q0.16, four pipeline stages.
// ----------------------------------------------------------------------------
module fgn_fade (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_t,
    output logic [15:0] o_f
);

    logic [31:0]        w_tt;
    logic signed [20:0] w_inner;
    logic [31:0]        w_t3p;
    logic signed [37:0] w_it;
    logic signed [21:0] w_poly;
    logic [36:0]        w_fp;

    logic [15:0]        r_s1_t2;
    logic [15:0]        r_s1_t;
    logic signed [20:0] r_s1_inner;
    logic [15:0]        r_s2_t3;
    logic [20:0]        r_s2_poly;
    logic [20:0]        r_s3_f;
    logic [15:0]        r_s4_f;

    assign w_tt    = 32'(i_t) * 32'(i_t);
    assign w_inner = $signed({5'b0, i_t}) * 21'sd6 - 21'sd983040;
    assign w_t3p   = 32'(r_s1_t2) * 32'(r_s1_t);
    assign w_it    = r_s1_inner * $signed({1'b0, r_s1_t});
    assign w_poly  = $signed(w_it[37:16]) + 22'sd655360;
    assign w_fp    = 37'(r_s2_t3) * 37'(r_s2_poly);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_t2    <= w_tt[31:16];
            r_s1_t     <= i_t;
            r_s1_inner <= w_inner;
            r_s2_t3    <= w_t3p[31:16];
            r_s2_poly  <= w_poly[20:0];
            r_s3_f     <= w_fp[36:16];
            // clamp to the top of Q0.16
            r_s4_f     <= (r_s3_f > 21'd65535) ? 16'hffff : r_s3_f[15:0];
        end
    end

    assign o_f = r_s4_f;

endmodule

[sv/fgn_octave_cell.sv]
// ----------------------------------------------------------------------------
// fgn_octave_cell
// One octave of tileable gradient noise; adds its weighted value to the
// running sum and hands texel and sum to the next cell. Ten stages.
// ----------------------------------------------------------------------------
module fgn_octave_cell #(
    parameter int TILE_SIZE  = fgn_pkg::DEF_TILE_SIZE,
    parameter int OCTAVES    = fgn_pkg::DEF_OCTAVES,
    parameter int BASE_CELLS = fgn_pkg::DEF_BASE_CELLS,
    parameter int OCT        = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [31:0]         i_base_seed,
    input  fgn_pkg::t_cell_bus  i_bus,
    output fgn_pkg::t_cell_bus  o_bus
);

    localparam int PERIOD = BASE_CELLS << OCT;
    localparam int CW     = (PERIOD > 1) ? $clog2(PERIOD) : 1;
    localparam int DEN    = 2 * TILE_SIZE;
    localparam int WSH    = OCTAVES - 1 - OCT;
    localparam int STAGES = 10;
    localparam int TW     = fgn_pkg::TOTAL_W;
    localparam int DOT_W  = 35;
    localparam int DIF_W  = 36;
    localparam int HL_W   = 37;

    // per-texel lattice tables
    logic [CW-1:0] w_lo_tab   [fgn_pkg::TEX_N];
    logic [CW-1:0] w_hi_tab   [fgn_pkg::TEX_N];
    logic [15:0]   w_frac_tab [fgn_pkg::TEX_N];

    for (genvar t = 0; t < fgn_pkg::TEX_N; t++) begin : g_tab
        localparam int NUM  = (2 * t + 1) * PERIOD;
        localparam int CELL = NUM / DEN;
        assign w_lo_tab[t]   = CW'(CELL % PERIOD);
        assign w_hi_tab[t]   = CW'((CELL + 1) % PERIOD);
        assign w_frac_tab[t] = 16'(((NUM % DEN) * 65536) / DEN);
    end

    // sequencing
    logic                 r_vld [STAGES];
    logic [7:0]           r_tx  [STAGES];
    logic [7:0]           r_ty  [STAGES];
    logic signed [TW-1:0] r_tot [STAGES-1];
    logic signed [TW-1:0] r_tot_out;

    // datapath
    logic [31:0]             w_seed;
    logic [31:0]             r_seed_mul;
    logic [CW-1:0]           r_s0_x0, r_s0_x1, r_s0_y0, r_s0_y1;
    logic [15:0]             r_s0_fx, r_s0_fy;
    logic [31:0]             r_s1_mx [2];
    logic [31:0]             r_s1_my [2];
    logic [15:0]             r_s1_fx, r_s1_fy;
    logic [31:0]             r_s2_h [4];
    logic [15:0]             r_s2_fx, r_s2_fy;
    logic [31:0]             r_s3_h [4];
    logic [15:0]             r_s3_fx, r_s3_fy;
    logic [31:0]             r_s4_h [4];
    logic [15:0]             r_s4_fx, r_s4_fy;
    logic signed [DOT_W-1:0] r_s5_c [4];
    logic [15:0]             r_s5_sx, r_s5_sy;
    logic signed [52:0]      r_s6_pl, r_s6_ph;
    logic signed [DOT_W-1:0] r_s6_c0, r_s6_c2;
    logic [15:0]             r_s6_sy;
    logic signed [DIF_W-1:0] r_s7_lo, r_s7_hi;
    logic [15:0]             r_s7_sy;
    logic signed [53:0]      r_s8_p;
    logic signed [DIF_W-1:0] r_s8_lo;

    logic [15:0]             w_sx, w_sy;
    logic [31:0]             w_h2 [4];
    logic [31:0]             w_g4 [4];
    logic [2:0]              w_code [4];
    logic signed [17:0]      w_ox [4];
    logic signed [17:0]      w_oy [4];
    logic signed [33:0]      w_px [4];
    logic signed [33:0]      w_py [4];
    logic signed [DIF_W-1:0] w_dl, w_dh;
    logic signed [HL_W-1:0]  w_dv;
    logic signed [DIF_W-1:0] w_v;
    logic signed [TW-1:0]    w_wv;

    assign w_seed = i_base_seed + 32'(OCT);

    // the user must let seed move only while idle; this block does not enforce it. Refresh its hash term every cycle
    always_ff @(posedge i_clk) begin
        r_seed_mul <= w_seed * fgn_pkg::HASH_SEED_MUL;
    end

    fgn_fade u_fade_x (.i_clk(i_clk), .i_en(i_en), .i_t(r_s0_fx), .o_f(w_sx));
    fgn_fade u_fade_y (.i_clk(i_clk), .i_en(i_en), .i_t(r_s0_fy), .o_f(w_sy));

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_h2[c]   = r_s1_mx[c[0]] + r_s1_my[c[1]] + r_seed_mul;
            w_g4[c]   = r_s3_h[c] ^ (r_s3_h[c] >> 12);
            w_code[c] = r_s4_h[c][2:0] ^ r_s4_h[c][17:15];
            w_ox[c]   = c[0] ? $signed({2'b0, r_s4_fx}) - 18'sd65536
                             : $signed({2'b0, r_s4_fx});
            w_oy[c]   = c[1] ? $signed({2'b0, r_s4_fy}) - 18'sd65536
                             : $signed({2'b0, r_s4_fy});
            w_px[c]   = fgn_pkg::GRAD_X[w_code[c]] * w_ox[c];
            w_py[c]   = fgn_pkg::GRAD_Y[w_code[c]] * w_oy[c];
        end
    end

    assign w_dl = DIF_W'(r_s5_c[1]) - DIF_W'(r_s5_c[0]);
    assign w_dh = DIF_W'(r_s5_c[3]) - DIF_W'(r_s5_c[2]);
    assign w_dv = HL_W'(r_s7_hi) - HL_W'(r_s7_lo);
    assign w_v  = r_s8_lo + DIF_W'(r_s8_p >>> 16);
    assign w_wv = TW'(w_v) <<< WSH;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '{default: 1'b0};
        end else if (i_en) begin
            r_vld[0] <= i_bus.valid;
            for (int s = 1; s < STAGES; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tx[0]  <= i_bus.tex_x;
            r_ty[0]  <= i_bus.tex_y;
            r_tot[0] <= i_bus.total;
            for (int s = 1; s < STAGES; s++) begin
                r_tx[s] <= r_tx[s-1];
                r_ty[s] <= r_ty[s-1];
            end
            for (int s = 1; s < STAGES - 1; s++) begin
                r_tot[s] <= r_tot[s-1];
            end

            // lattice corners and fractions
            r_s0_x0 <= w_lo_tab[i_bus.tex_x];
            r_s0_x1 <= w_hi_tab[i_bus.tex_x];
            r_s0_y0 <= w_lo_tab[i_bus.tex_y];
            r_s0_y1 <= w_hi_tab[i_bus.tex_y];
            r_s0_fx <= w_frac_tab[i_bus.tex_x];
            r_s0_fy <= w_frac_tab[i_bus.tex_y];

            // hash: coordinate terms, mix, two rounds of multiply
            r_s1_mx[0] <= 32'(r_s0_x0) * fgn_pkg::HASH_X_MUL;
            r_s1_mx[1] <= 32'(r_s0_x1) * fgn_pkg::HASH_X_MUL;
            r_s1_my[0] <= 32'(r_s0_y0) * fgn_pkg::HASH_Y_MUL;
            r_s1_my[1] <= 32'(r_s0_y1) * fgn_pkg::HASH_Y_MUL;
            r_s1_fx    <= r_s0_fx;
            r_s1_fy    <= r_s0_fy;
            for (int c = 0; c < 4; c++) begin
                r_s2_h[c] <= w_h2[c] ^ (w_h2[c] >> 15);
                r_s3_h[c] <= r_s2_h[c] * fgn_pkg::HASH_MIX1;
                r_s4_h[c] <= w_g4[c] * fgn_pkg::HASH_MIX2;
                r_s5_c[c] <= DOT_W'(w_px[c]) + DOT_W'(w_py[c]);
            end
            r_s2_fx <= r_s1_fx;
            r_s2_fy <= r_s1_fy;
            r_s3_fx <= r_s2_fx;
            r_s3_fy <= r_s2_fy;
            r_s4_fx <= r_s3_fx;
            r_s4_fy <= r_s3_fy;
            r_s5_sx <= w_sx;
            r_s5_sy <= w_sy;

            // blend along x, then along y
            r_s6_pl <= w_dl * $signed({1'b0, r_s5_sx});
            r_s6_ph <= w_dh * $signed({1'b0, r_s5_sx});
            r_s6_c0 <= r_s5_c[0];
            r_s6_c2 <= r_s5_c[2];
            r_s6_sy <= r_s5_sy;
            r_s7_lo <= DIF_W'(r_s6_c0) + DIF_W'(r_s6_pl >>> 16);
            r_s7_hi <= DIF_W'(r_s6_c2) + DIF_W'(r_s6_ph >>> 16);
            r_s7_sy <= r_s6_sy;
            r_s8_p  <= w_dv * $signed({1'b0, r_s7_sy});
            r_s8_lo <= r_s7_lo;

            // accumulate with octave weight
            r_tot_out <= r_tot[STAGES-2] + w_wv;
        end
    end

    assign o_bus.valid = r_vld[STAGES-1];
    assign o_bus.tex_x = r_tx[STAGES-1];
    assign o_bus.tex_y = r_ty[STAGES-1];
    assign o_bus.total = r_tot_out;

endmodule

[sv/fgn_div.sv]
// ----------------------------------------------------------------------------
// fgn_div
// Scales the octave sum by the weight total: round, saturate, and divide
// by 2^OCTAVES-1 with a reciprocal multiply. Three stages.
// ----------------------------------------------------------------------------
module fgn_div #(
    parameter int OCTAVES = fgn_pkg::DEF_OCTAVES
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_vld,
    input  logic signed [fgn_pkg::TOTAL_W-1:0]     i_total,
    output logic                                   o_vld,
    output logic signed [fgn_pkg::NOISE_W-1:0]     o_noise
);

    localparam int TW   = fgn_pkg::TOTAL_W;
    localparam int QW   = TW - 16;
    localparam int W    = (1 << OCTAVES) - 1;
    localparam int DW   = 16 + OCTAVES;
    localparam int MW   = DW + 2;
    localparam int PW   = DW + MW;
    localparam int SH   = DW + OCTAVES;
    localparam int NV   = 3;

    localparam logic signed [TW-1:0] BIAS    = TW'(W * 32768);
    localparam logic signed [QW-1:0] Q_LO    = QW'(-(W * 32768));
    localparam logic signed [QW-1:0] Q_HI    = QW'(W * 32768 - 1);
    localparam logic signed [QW-1:0] Q_SHIFT = QW'(W * 32768);

    // ceil(2^SH / W): exact floor division for every dividend below 2^DW
    localparam longint          RECIP_L = ((longint'(1) << SH) + longint'(W) - 1)
                                          / longint'(W);
    localparam logic [MW-1:0]   RECIP   = MW'(RECIP_L);

    logic                 r_vld [NV];
    logic signed [TW-1:0] r_x;
    logic [DW-1:0]        r_qq;
    logic [PW-1:0]        r_prod;

    logic signed [QW-1:0] w_q;
    logic signed [QW-1:0] w_qc;
    logic signed [QW-1:0] w_qs;
    logic [15:0]          w_quo;

    // floor(x / 65536), clamp to the quotient range, offset to non-negative
    assign w_q  = $signed(r_x[TW-1:16]);
    assign w_qc = (w_q < Q_LO) ? Q_LO : ((w_q > Q_HI) ? Q_HI : w_q);
    assign w_qs = w_qc + Q_SHIFT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '{default: 1'b0};
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int s = 1; s < NV; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= i_total + BIAS;
            r_qq   <= w_qs[DW-1:0];
            r_prod <= PW'(r_qq) * PW'(RECIP);
        end
    end

    assign w_quo = r_prod[SH +: 16];

    // remove the offset of 32768 from the quotient
    assign o_vld   = r_vld[NV-1];
    assign o_noise = $signed({~w_quo[15], w_quo[14:0]});

endmodule
